>>> hdl/mkpq_pkg.sv
`timescale 1ns / 1ps

package mkpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int GROUP_SIZE  = 4;
	localparam int NUM_GROUPS  = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam int OP_W      = 2;
	localparam int KEY_W     = 16;
	localparam int PAYLOAD_W = 32;
	localparam int STATUS_W  = 2;
	localparam int HELD_W    = 5;

	localparam logic [OP_W-1:0] OP_INSERT        = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE_OLDEST = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_MIN    = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY         = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef logic [KEY_W-1:0]     key_t;
	typedef logic [PAYLOAD_W-1:0] payload_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		key_t     key;
		payload_t payload;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		key_t key;
		idx_t idx;
	} cand_t;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		key_t            entry_key;
		payload_t        entry_payload;
	} cmd_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		key_t                removed_key;
		payload_t            removed_payload;
		key_t                min_key;
		payload_t            min_payload;
		key_t                front_key;
		payload_t            front_payload;
		logic [HELD_W-1:0]   held_count;
	} res_item_t;

endpackage

>>> hdl/mkpq_cell.sv
`timescale 1ns / 1ps

module mkpq_cell
	import mkpq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     new_entry,
	input  entry_t     next_entry,
	output entry_t     entry
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= new_entry;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

>>> hdl/mkpq_min_tree.sv
`timescale 1ns / 1ps

module mkpq_min_tree
	import mkpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  key_t keys [QUEUE_DEPTH],
	input  cnt_t count,
	output cand_t winner
);

	cand_t grp_s1 [NUM_GROUPS];
	cand_t grp_d  [NUM_GROUPS];

	// group winners, scanned in slot order so the oldest wins ties
	always_comb begin
		cand_t best;
		int    idx;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			best = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				idx = g * GROUP_SIZE + j;
				if (idx < QUEUE_DEPTH) begin
					if (CNT_W'(idx) < count && (!best.valid || keys[idx] < best.key)) begin
						best.valid = 1'b1;
						best.key   = keys[idx];
						best.idx   = IDX_W'(idx);
					end
				end
			end
			grp_d[g] = best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_s1[g] <= '0;
			end
		end else begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_s1[g] <= grp_d[g];
			end
		end
	end

	always_comb begin
		cand_t best;
		best = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (grp_s1[g].valid && (!best.valid || grp_s1[g].key < best.key)) begin
				best = grp_s1[g];
			end
		end
		winner = best;
	end

endmodule

>>> hdl/min_key_priority_queue_unit.sv
`timescale 1ns / 1ps
// Minimum-key priority queue, entries kept in arrival order in a row of cells.
// cmd channel (cmd_valid/cmd_ready/cmd): one transaction per item; operation
// inserts at the back, removes the oldest, removes the smallest key (oldest
// on ties, later entries close up) or only queries.
// res channel (res_valid/res_ready/res): exactly one transaction per item with
// status, removed entry, current minimum and front entries and the count.
// res_valid rises after the FSM has passed S_TREE1 and S_TREE2. The cells are
// updated at the cmd edge, then a two-stage compare tree (group minimum,
// registered, then final minimum) finds the new minimum for the result and for
// the next remove-min. No new item is taken until the last result is registered.
// cmd_ready is high only while no item is in flight; a result still waiting in
// the output register does not block the next cmd transaction.
// If the receiver stalls, the finished item waits in the last tree stage until
// the output register frees, and cmd_ready stays low meanwhile.
// Reset (arst_n low) empties the queue, drops any pending result and leaves
// cmd_ready high; cell contents are not cleared and are never reported.

module min_key_priority_queue_unit
	import mkpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_TREE1 = 2'd1;
	localparam logic [1:0] S_TREE2 = 2'd2;

	logic [1:0] state_q;
	cnt_t       count_q;
	idx_t       min_idx_q;
	logic       res_valid_q;
	res_item_t  res_q;

	logic [STATUS_W-1:0] status_q;
	key_t                rem_key_q;
	payload_t            rem_payload_q;

	entry_t     cells [QUEUE_DEPTH];
	key_t       keys  [QUEUE_DEPTH];
	cell_ctrl_t ctrl  [QUEUE_DEPTH];
	cand_t      winner;

	logic   accept;
	logic   is_ins;
	logic   is_rem;
	logic   do_ins;
	logic   do_rem;
	idx_t   rem_pos;
	entry_t new_entry;
	logic   res_free;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign is_ins    = (cmd.operation == OP_INSERT);
	assign is_rem    = cmd.operation inside {OP_REMOVE_OLDEST, OP_REMOVE_MIN};
	assign do_ins    = accept && is_ins && (count_q != CNT_W'(QUEUE_DEPTH));
	assign do_rem    = accept && is_rem && (count_q != '0);
	assign rem_pos   = (cmd.operation == OP_REMOVE_MIN) ? min_idx_q : '0;
	assign new_entry = '{key: cmd.entry_key, payload: cmd.entry_payload};
	assign res_free  = !res_valid_q || res_ready;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ctrl[i].load  = do_ins && (count_q == CNT_W'(i));
			ctrl[i].shift = do_rem && (i < QUEUE_DEPTH - 1) && (IDX_W'(i) >= rem_pos);
			keys[i]       = cells[i].key;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t next_entry;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_entry = cells[i];
		end else begin : g_mid
			assign next_entry = cells[i+1];
		end
		mkpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.new_entry  (new_entry),
			.next_entry (next_entry),
			.entry      (cells[i])
		);
	end

	mkpq_min_tree u_min_tree (
		.clk    (clk),
		.arst_n (arst_n),
		.keys   (keys),
		.count  (count_q),
		.winner (winner)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_ins && !do_ins) begin
				status_q <= ST_FULL;
			end else if (is_rem && !do_rem) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
			rem_key_q     <= do_rem ? cells[rem_pos].key : '0;
			rem_payload_q <= do_rem ? cells[rem_pos].payload : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			min_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_rem) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == S_TREE2 && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_TREE1;
					end
				end
				S_TREE1: begin
					state_q <= S_TREE2;
				end
				S_TREE2: begin
					if (res_free) begin
						min_idx_q <= winner.valid ? winner.idx : '0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TREE2 && res_free) begin
			res_q.status          <= status_q;
			res_q.removed_key     <= rem_key_q;
			res_q.removed_payload <= rem_payload_q;
			res_q.min_key         <= winner.valid ? winner.key : '0;
			res_q.min_payload     <= winner.valid ? cells[winner.idx].payload : '0;
			res_q.front_key       <= winner.valid ? cells[0].key : '0;
			res_q.front_payload   <= winner.valid ? cells[0].payload : '0;
			res_q.held_count      <= HELD_W'(count_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("held count exceeds queue depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
			count_q == $past(count_q) - 1'b1))
		else $error("count moved by more than one entry");

	a_min_idx_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q != '0) |-> (CNT_W'(min_idx_q) < count_q))
		else $error("minimum index points past held entries");

	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_TREE1 && !cmd_ready))
		else $error("transaction accepted without starting the search");
`endif

endmodule

>>> sim/tb_min_key_priority_queue_unit.sv
`timescale 1ns / 1ps

module tb_min_key_priority_queue_unit;
	import mkpq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 256;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res;

	cmd_item_t pending_cmds[$];
	res_item_t awaited_results[$];
	entry_t    held_entries[$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	bit  cmd_taken = 1'b0;
	bit  progress;
	int  idle_cycles = 0;
	int  mismatches = 0;
	int  results_checked = 0;
	int  op_count[4] = '{default: 0};
	int  empty_removals = 0;
	int  dropped_inserts = 0;
	int  peak_fill = 0;
	res_item_t want;

	min_key_priority_queue_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// smallest key, oldest on ties
	function automatic int min_slot();
		int best;
		best = 0;
		for (int i = 1; i < held_entries.size(); i++)
			if (held_entries[i].key < held_entries[best].key)
				best = i;
		return best;
	endfunction

	function automatic res_item_t queue_step(cmd_item_t c);
		res_item_t r;
		entry_t    e;
		int        pos;
		r = '0;
		r.status = ST_OK;
		case (c.operation)
			OP_INSERT: begin
				if (held_entries.size() >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					e.key = c.entry_key;
					e.payload = c.entry_payload;
					held_entries.push_back(e);
				end
			end
			OP_REMOVE_OLDEST, OP_REMOVE_MIN: begin
				if (held_entries.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = (c.operation == OP_REMOVE_MIN) ? min_slot() : 0;
					r.removed_key = held_entries[pos].key;
					r.removed_payload = held_entries[pos].payload;
					held_entries.delete(pos);
				end
			end
			default: ;
		endcase
		if (held_entries.size() > 0) begin
			pos = min_slot();
			r.min_key = held_entries[pos].key;
			r.min_payload = held_entries[pos].payload;
			r.front_key = held_entries[0].key;
			r.front_payload = held_entries[0].payload;
		end
		r.held_count = HELD_W'(held_entries.size());
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0h, got %0h",
					results_checked, name, exp_v, got_v);
		end
	endtask

	task automatic push_cmd(logic [OP_W-1:0] op, key_t k, payload_t p);
		cmd_item_t c;
		c.operation = op;
		c.entry_key = k;
		c.entry_payload = p;
		pending_cmds.push_back(c);
	endtask

	function automatic cmd_item_t random_cmd(int insert_pct);
		cmd_item_t c;
		int        r;
		r = $urandom_range(99);
		if (r < insert_pct)
			c.operation = OP_INSERT;
		else if (r < 93)
			c.operation = $urandom_range(1) ? OP_REMOVE_MIN : OP_REMOVE_OLDEST;
		else
			c.operation = OP_QUERY;
		case ($urandom_range(3))
			0: c.entry_key = key_t'($urandom_range(7));
			1: c.entry_key = $urandom_range(1) ? '1 : '0;
			default: c.entry_key = key_t'($urandom);
		endcase
		c.entry_payload = $urandom;
		return c;
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || cmd_valid || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// insert-heavy and remove-heavy stretches so the queue swings between empty and full
	task automatic run_phase(int send_idle, int recv_stall, bit long_hold);
		int tide;
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		tide = 50;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % 32 == 0)
				case ($urandom_range(2))
					0: tide = 25;
					1: tide = 50;
					default: tide = 88;
				endcase
			pending_cmds.push_back(random_cmd(tide));
		end
		if (long_hold)
			hold_request = 1'b1;
		wait_drained();
	endtask

	// sender
	always @(negedge clk) begin
		if (cmd_taken || !cmd_valid) begin
			cmd_taken = 1'b0;
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (cmd_valid && cmd_ready) begin
				want = queue_step(cmd);
				awaited_results.push_back(want);
				op_count[cmd.operation]++;
				if (want.status == ST_EMPTY)
					empty_removals++;
				if (want.status == ST_FULL)
					dropped_inserts++;
				if (held_entries.size() > peak_fill)
					peak_fill = held_entries.size();
				cmd_taken = 1'b1;
				progress = 1'b1;
			end
			if (res_valid && res_ready) begin
				progress = 1'b1;
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: %p", res);
				end else begin
					want = awaited_results.pop_front();
					check_field("status", want.status, res.status);
					check_field("removed_key", want.removed_key, res.removed_key);
					check_field("removed_payload", want.removed_payload, res.removed_payload);
					check_field("min_key", want.min_key, res.min_key);
					check_field("min_payload", want.min_payload, res.min_payload);
					check_field("front_key", want.front_key, res.front_key);
					check_field("front_payload", want.front_payload, res.front_payload);
					check_field("held_count", want.held_count, res.held_count);
				end
				results_checked++;
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					idle_cycles, awaited_results.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue, extremes, tie on equal keys, fill to full, drop, remove oldest
		push_cmd(OP_QUERY, 16'h1234, 32'h5678_9abc);
		push_cmd(OP_REMOVE_OLDEST, '1, '1);
		push_cmd(OP_REMOVE_MIN, '0, '0);
		push_cmd(OP_INSERT, '1, '1);
		push_cmd(OP_INSERT, '0, '0);
		push_cmd(OP_INSERT, 16'd7, 32'd1);
		push_cmd(OP_INSERT, 16'd7, 32'd2);
		push_cmd(OP_REMOVE_MIN, '0, '0);
		push_cmd(OP_REMOVE_MIN, '0, '0);
		for (int i = 0; i < QUEUE_DEPTH - 2; i++)
			push_cmd(OP_INSERT, key_t'(i % 4 + 3), payload_t'(32'h1000 + i));
		push_cmd(OP_INSERT, 16'hbeef, 32'hdead_beef);
		push_cmd(OP_REMOVE_OLDEST, '0, '0);
		wait_drained();

		run_phase(0, 0, 1'b1);
		run_phase(68, 0, 1'b0);
		run_phase(0, 68, 1'b0);
		run_phase(22, 22, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);

		$display("covered %0d inserts, %0d oldest and %0d min removals, %0d queries; %0d results",
			op_count[OP_INSERT], op_count[OP_REMOVE_OLDEST], op_count[OP_REMOVE_MIN],
			op_count[OP_QUERY], results_checked);
		$display("removals from empty: %0d, dropped inserts: %0d, peak fill %0d, mismatches %0d",
			empty_removals, dropped_inserts, peak_fill, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
